>>> hw/rtl/frfs_pkg.sv
`default_nettype none
package frfs_pkg;

  localparam int unsigned MAX_CHUNKS  = 256;
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned SIZE_BITS   = 40;

  localparam int unsigned CHUNK_W = 8;
  localparam int unsigned ENTRY_W = 10;
  localparam int unsigned PORT_SIZE_W = 40;
  localparam int unsigned SIZE_W = (SIZE_BITS < PORT_SIZE_W) ? SIZE_BITS : PORT_SIZE_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_IDX_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_t;

  typedef struct packed {
    logic               fits;
    logic               settle;
    logic               best;
    logic               worst;
    logic [CHUNK_W-1:0] chunk;
    logic [ENTRY_W-1:0] entry;
    logic [SIZE_W-1:0]  size;
    logic               last;
  } item_t;

endpackage
`default_nettype wire

>>> hw/rtl/frfs_ifs.sv
`default_nettype none
interface frfs_in_if;
  logic        valid;
  logic        ready;
  logic        has_entry;
  logic [7:0]  chunk_index;
  logic [9:0]  entry_index;
  logic [39:0] range_size;
  logic [39:0] request_size;
  logic        last;

  modport source (output valid, has_entry, chunk_index, entry_index, range_size,
                  request_size, last, input ready);
  modport sink (input valid, has_entry, chunk_index, entry_index, range_size,
                request_size, last, output ready);
endinterface

interface frfs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [7:0]  chosen_chunk;
  logic [9:0]  chosen_entry;
  logic [39:0] chosen_size;

  modport source (output valid, found, chosen_chunk, chosen_entry, chosen_size,
                  input ready);
  modport sink (input valid, found, chosen_chunk, chosen_entry, chosen_size,
                output ready);
endinterface

interface frfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] fit_mode;

  modport source (output valid, fit_mode, input ready);
  modport sink (input valid, fit_mode, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/free_range_fit_search_top.sv
// datapath: an accepted word is written into the queue, and a scan end's result into the output register
// throughput: one word per cycle, limited by the two-entry queue and output register
// the back end updates the candidate once per word; a stalled output holds only scan ends
// reset: synchronous, active high; clears mode to first fit, the queue, the search
// state and the output valid
`default_nettype none
module free_range_fit_search_top #(
  parameter int unsigned MAX_CHUNKS  = frfs_pkg::MAX_CHUNKS,
  parameter int unsigned MAX_ENTRIES = frfs_pkg::MAX_ENTRIES
) (
  input  wire logic   clk,
  input  wire logic   rst,
  frfs_in_if.sink     in,
  frfs_cfg_if.sink    cfg,
  frfs_out_if.source  out
);

  frfs_pkg::item_t wr_item;
  frfs_pkg::item_t rd_item;
  logic push;
  logic full;
  logic pop;
  logic not_empty;

  frfs_front #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .in   (in),
    .cfg  (cfg),
    .full (full),
    .item (wr_item),
    .push (push)
  );

  frfs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (wr_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rd_item   (rd_item)
  );

  frfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .item      (rd_item),
    .pop       (pop),
    .out       (out)
  );

endmodule
`default_nettype wire

>>> hw/rtl/frfs_front.sv
`default_nettype none
module frfs_front #(
  parameter int unsigned MAX_CHUNKS  = frfs_pkg::MAX_CHUNKS,
  parameter int unsigned MAX_ENTRIES = frfs_pkg::MAX_ENTRIES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  frfs_in_if.sink            in,
  frfs_cfg_if.sink           cfg,
  input  wire logic          full,
  output frfs_pkg::item_t    item,
  output logic               push
);

  frfs_pkg::fit_mode_t mode;
  logic [frfs_pkg::SIZE_W-1:0] fsize;
  logic [frfs_pkg::SIZE_W-1:0] req;
  logic in_range;
  logic ge;
  logic eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= frfs_pkg::FIT_FIRST;
    end else if (cfg.valid && cfg.ready) begin
      mode <= frfs_pkg::fit_mode_t'(cfg.fit_mode);
    end
  end

  assign cfg.ready = 1'b1;
  assign in.ready  = !full;
  assign push      = in.valid && !full;

  assign fsize    = in.range_size[frfs_pkg::SIZE_W-1:0];
  assign req      = in.request_size[frfs_pkg::SIZE_W-1:0];
  assign in_range = (32'(in.chunk_index) < 32'(MAX_CHUNKS)) &&
                    (32'(in.entry_index) < 32'(MAX_ENTRIES));
  assign ge = fsize >= req;
  assign eq = fsize == req;

  always_comb begin
    item.fits  = in.has_entry && in_range && ge;
    item.chunk = in.chunk_index;
    item.entry = in.entry_index;
    item.size  = fsize;
    item.last  = in.last;
    case (mode)
      frfs_pkg::FIT_BEST: begin
        item.settle = eq;
        item.best   = 1'b1;
        item.worst  = 1'b0;
      end
      frfs_pkg::FIT_WORST: begin
        item.settle = eq;
        item.best   = 1'b0;
        item.worst  = 1'b1;
      end
      default: begin
        item.settle = 1'b1;
        item.best   = 1'b0;
        item.worst  = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/frfs_fifo.sv
`default_nettype none
module frfs_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire frfs_pkg::item_t  wr_item,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output frfs_pkg::item_t       rd_item
);

  frfs_pkg::item_t mem [frfs_pkg::QUEUE_DEPTH];
  logic [frfs_pkg::QUEUE_IDX_W-1:0] wr_ptr;
  logic [frfs_pkg::QUEUE_IDX_W-1:0] rd_ptr;
  logic [frfs_pkg::QUEUE_CNT_W-1:0] count;

  assign full      = count == frfs_pkg::QUEUE_CNT_W'(frfs_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/frfs_back.sv
`default_nettype none
module frfs_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             not_empty,
  input  wire frfs_pkg::item_t  item,
  output logic                  pop,
  frfs_out_if.source            out
);

  logic have_candidate;
  logic locked;
  logic [frfs_pkg::CHUNK_W-1:0] cand_chunk;
  logic [frfs_pkg::ENTRY_W-1:0] cand_entry;
  logic [frfs_pkg::SIZE_W-1:0]  cand_size;

  logic have_next;
  logic locked_next;
  logic [frfs_pkg::CHUNK_W-1:0] chunk_next;
  logic [frfs_pkg::ENTRY_W-1:0] entry_next;
  logic [frfs_pkg::SIZE_W-1:0]  size_next;
  logic take;
  logic out_valid;

  assign pop = not_empty && (!item.last || !out_valid || out.ready);

  assign take = item.fits && !locked &&
                (item.settle || !have_candidate ||
                 (item.best && (item.size < cand_size)) ||
                 (item.worst && (item.size > cand_size)));

  assign have_next   = have_candidate || take;
  assign locked_next = locked || (take && item.settle);
  assign chunk_next  = take ? item.chunk : cand_chunk;
  assign entry_next  = take ? item.entry : cand_entry;
  assign size_next   = take ? item.size  : cand_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_candidate <= 1'b0;
      locked         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        have_candidate <= item.last ? 1'b0 : have_next;
        locked         <= item.last ? 1'b0 : locked_next;
      end
      if (pop && item.last) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !item.last) begin
      cand_chunk <= chunk_next;
      cand_entry <= entry_next;
      cand_size  <= size_next;
    end
    if (pop && item.last) begin
      out.found        <= have_next;
      out.chosen_chunk <= have_next ? chunk_next : '0;
      out.chosen_entry <= have_next ? entry_next : '0;
      out.chosen_size  <= have_next ? frfs_pkg::PORT_SIZE_W'(size_next) : '0;
    end
  end

  assign out.valid = out_valid;

  a_lock_has_cand: assert property (@(posedge clk) disable iff (rst)
    locked |-> have_candidate)
    else $error("locked without a candidate");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.found) |->
      (out.chosen_chunk == '0 && out.chosen_entry == '0 && out.chosen_size == '0))
    else $error("empty result carries nonzero fields");

  a_scan_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && item.last) |=> (!have_candidate && !locked && out.valid))
    else $error("scan end did not clear search state");

endmodule
`default_nettype wire

>>> dv/tb_free_range_fit_search_top.sv
`default_nettype none
module tb_free_range_fit_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  FIT_UNUSED = 2'd3;
  localparam logic [39:0] SZ_MAX     = {40{1'b1}};

  typedef struct packed {
    logic                         has_entry;
    logic [frfs_pkg::CHUNK_W-1:0] chunk;
    logic [frfs_pkg::ENTRY_W-1:0] entry;
    logic [39:0]                  fsize;
    logic [39:0]                  req;
    logic                         last;
  } scan_word_t;

  typedef struct packed {
    logic                         found;
    logic [frfs_pkg::CHUNK_W-1:0] chunk;
    logic [frfs_pkg::ENTRY_W-1:0] entry;
    logic [39:0]                  size;
  } fit_result_t;

  typedef struct packed {
    logic [1:0]  mode;
    scan_word_t  word;
    logic        typed;
    fit_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  frfs_in_if  in_ch ();
  frfs_cfg_if cfg_ch ();
  frfs_out_if out_ch ();

  free_range_fit_search_top u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .cfg (cfg_ch),
    .out (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted search state
  logic [1:0]  cur_mode = frfs_pkg::FIT_FIRST;
  fit_result_t cand = '0;
  logic        srch_locked = 1'b0;

  fit_result_t fit_pending[$];
  int          errors = 0;
  int          tx_odds = 0;
  int          rx_odds = 0;
  int          rx_left = 0;

  logic [1:0] phase_modes [0:6] = '{frfs_pkg::FIT_BEST, frfs_pkg::FIT_WORST, FIT_UNUSED,
                                    frfs_pkg::FIT_FIRST, frfs_pkg::FIT_WORST,
                                    frfs_pkg::FIT_BEST, frfs_pkg::FIT_FIRST};

  dir_row_t dir_rows [0:26] = '{
    // empty end marker right after reset
    '{frfs_pkg::FIT_FIRST, '{1'b0, 8'd0, 10'd0, 40'd0, 40'd1, 1'b1}, 1'b1,
      '{1'b0, 8'd0, 10'd0, 40'd0}},
    '{frfs_pkg::FIT_FIRST, '{1'b1, 8'd3, 10'd5, 40'd100, 40'd200, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_FIRST, '{1'b1, 8'd4, 10'd6, 40'd300, 40'd200, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_FIRST, '{1'b1, 8'd255, 10'd1023, 40'd250, 40'd200, 1'b1}, 1'b1,
      '{1'b1, 8'd4, 10'd6, 40'd300}},
    '{frfs_pkg::FIT_FIRST, '{1'b1, 8'd255, 10'd1023, SZ_MAX, SZ_MAX, 1'b1}, 1'b1,
      '{1'b1, 8'd255, 10'd1023, SZ_MAX}},
    // zero request, zero size
    '{frfs_pkg::FIT_FIRST, '{1'b1, 8'd0, 10'd0, 40'd0, 40'd0, 1'b1}, 1'b1,
      '{1'b1, 8'd0, 10'd0, 40'd0}},
    '{frfs_pkg::FIT_BEST, '{1'b1, 8'd1, 10'd1, 40'd500, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_BEST, '{1'b1, 8'd2, 10'd2, 40'd200, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_BEST, '{1'b1, 8'd3, 10'd3, 40'd200, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_BEST, '{1'b1, 8'd4, 10'd4, 40'd50, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_BEST, '{1'b0, 8'd9, 10'd9, 40'd150, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_BEST, '{1'b1, 8'd5, 10'd5, 40'd300, 40'd100, 1'b1}, 1'b1,
      '{1'b1, 8'd2, 10'd2, 40'd200}},
    '{frfs_pkg::FIT_BEST, '{1'b1, 8'd6, 10'd7, 40'd150, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_BEST, '{1'b1, 8'd7, 10'd8, 40'd100, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_BEST, '{1'b1, 8'd8, 10'd9, 40'd101, 40'd100, 1'b1}, 1'b1,
      '{1'b1, 8'd7, 10'd8, 40'd100}},
    '{frfs_pkg::FIT_BEST, '{1'b1, 8'd1, 10'd1, 40'd10, 40'h80_0000_0000, 1'b1}, 1'b1, '0},
    '{frfs_pkg::FIT_WORST, '{1'b1, 8'd1, 10'd1, 40'd500, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_WORST, '{1'b1, 8'd2, 10'd2, 40'd900, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_WORST, '{1'b1, 8'd3, 10'd3, 40'd900, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_WORST, '{1'b1, 8'd4, 10'd4, 40'd700, 40'd100, 1'b1}, 1'b1,
      '{1'b1, 8'd2, 10'd2, 40'd900}},
    '{frfs_pkg::FIT_WORST, '{1'b1, 8'd5, 10'd5, 40'd100, 40'd100, 1'b0}, 1'b0, '0},
    '{frfs_pkg::FIT_WORST, '{1'b1, 8'd6, 10'd6, SZ_MAX, 40'd100, 1'b1}, 1'b1,
      '{1'b1, 8'd5, 10'd5, 40'd100}},
    '{FIT_UNUSED, '{1'b1, 8'd10, 10'd20, 40'd40, 40'd50, 1'b0}, 1'b0, '0},
    '{FIT_UNUSED, '{1'b1, 8'd11, 10'd21, 40'd60, 40'd50, 1'b0}, 1'b0, '0},
    '{FIT_UNUSED, '{1'b1, 8'd12, 10'd22, 40'd1000, 40'd50, 1'b1}, 1'b1,
      '{1'b1, 8'd11, 10'd21, 40'd60}},
    // request changes inside the scan
    '{FIT_UNUSED, '{1'b1, 8'd1, 10'd1, 40'd30, 40'd50, 1'b0}, 1'b0, '0},
    '{FIT_UNUSED, '{1'b1, 8'd2, 10'd2, 40'd30, 40'd20, 1'b1}, 1'b0, '0}
  };

  function automatic logic [39:0] rand40();
    return 40'({$urandom, $urandom});
  endfunction

  function automatic logic [39:0] rand_req();
    case ($urandom_range(0, 5))
      0: return 40'd1;
      1: return SZ_MAX;
      2: return rand40();
      default: return 40'($urandom_range(1, 4000));
    endcase
  endfunction

  task automatic flag_error(input string what, input logic [39:0] got, input logic [39:0] want);
    $display("%0t: mismatch on %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic predict_fit(input scan_word_t w, output bit emits, output fit_result_t res);
    logic grab;
    logic lock_now;
    grab = 1'b0;
    lock_now = 1'b0;
    if (w.has_entry && !srch_locked && 32'(w.chunk) < frfs_pkg::MAX_CHUNKS &&
        32'(w.entry) < frfs_pkg::MAX_ENTRIES && w.fsize >= w.req) begin
      if (cur_mode == frfs_pkg::FIT_BEST || cur_mode == frfs_pkg::FIT_WORST) begin
        lock_now = (w.fsize == w.req);
        grab = lock_now || !cand.found ||
               (cur_mode == frfs_pkg::FIT_BEST ? w.fsize < cand.size : w.fsize > cand.size);
      end else begin
        grab = 1'b1;
        lock_now = 1'b1;
      end
    end
    if (grab) cand = '{1'b1, w.chunk, w.entry, w.fsize};
    if (lock_now) srch_locked = 1'b1;
    emits = w.last;
    res = cand;
    if (w.last) begin
      cand = '0;
      srch_locked = 1'b0;
    end
  endtask

  task automatic send_word(input scan_word_t w, input bit typed, input fit_result_t want);
    bit          emits;
    fit_result_t res;
    if (tx_odds != 0 && $urandom_range(0, tx_odds - 1) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.has_entry    <= w.has_entry;
    in_ch.chunk_index  <= w.chunk;
    in_ch.entry_index  <= w.entry;
    in_ch.range_size   <= w.fsize;
    in_ch.request_size <= w.req;
    in_ch.last         <= w.last;
    do @(posedge clk); while (!in_ch.ready);
    predict_fit(w, emits, res);
    if (emits) fit_pending.push_back(typed ? want : res);
  endtask

  // drain the block before touching the mode register
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (fit_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.fit_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_mode = m;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_left <= 0;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
      out_ch.ready <= (rx_left == 1);
    end else if (rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0) begin
      rx_left <= $urandom_range(0, 19);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fit_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (fit_pending.size() == 0) begin
        flag_error("unexpected word, found", 40'(out_ch.found), 40'd0);
      end else begin
        want = fit_pending.pop_front();
        if (out_ch.found !== want.found)
          flag_error("found", 40'(out_ch.found), 40'(want.found));
        if (out_ch.chosen_chunk !== want.chunk)
          flag_error("chosen_chunk", 40'(out_ch.chosen_chunk), 40'(want.chunk));
        if (out_ch.chosen_entry !== want.entry)
          flag_error("chosen_entry", 40'(out_ch.chosen_entry), 40'(want.entry));
        if (out_ch.chosen_size !== want.size)
          flag_error("chosen_size", out_ch.chosen_size, want.size);
      end
    end
  end

  initial begin
    scan_word_t  w;
    logic [39:0] req;
    logic [39:0] prev;
    logic [40:0] sum;
    int          len;
    int          sent;
    in_ch.valid        <= 1'b0;
    in_ch.has_entry    <= 1'b0;
    in_ch.chunk_index  <= '0;
    in_ch.entry_index  <= '0;
    in_ch.range_size   <= '0;
    in_ch.request_size <= '0;
    in_ch.last         <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.fit_mode    <= frfs_pkg::FIT_FIRST;
    rst                <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_odds = 4;
    rx_odds = 5;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) begin
        settle();
        write_mode(dir_rows[i].mode);
      end
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      write_mode(p == 7 ? 2'($urandom_range(0, 3)) : phase_modes[p]);
      tx_odds = (p == 2 || p == 7) ? 0 : $urandom_range(3, 12);
      rx_odds = (p == 2 || p == 7) ? 0 : $urandom_range(3, 12);
      sent = 0;
      while (sent < 200) begin
        req = rand_req();
        prev = req;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 29) == 0) req = rand_req();
          w.has_entry = ($urandom_range(0, 14) != 0);
          w.chunk = 8'($urandom);
          w.entry = 10'($urandom);
          w.req = req;
          case ($urandom_range(0, 7))
            0: w.fsize = req;
            1: w.fsize = prev;
            2: w.fsize = (req > 40'd50) ? req - 40'($urandom_range(1, 50)) : '0;
            3: w.fsize = rand40();
            4: w.fsize = SZ_MAX;
            default: begin
              sum = {1'b0, req} + 41'($urandom_range(1, 3000));
              w.fsize = sum[40] ? SZ_MAX : sum[39:0];
            end
          endcase
          if (w.has_entry) prev = w.fsize;
          w.last = (i == len - 1);
          send_word(w, 1'b0, '0);
          if (w.has_entry || w.last) sent++;
        end
      end
    end

    settle();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/frfs_pkg.sv
hw/rtl/frfs_ifs.sv
hw/rtl/frfs_front.sv
hw/rtl/frfs_fifo.sv
hw/rtl/frfs_back.sv
hw/rtl/free_range_fit_search_top.sv
dv/tb_free_range_fit_search_top.sv
